>>> rtl/eama_pkg.sv
// ----------------------------------------------------------------------------
// eama_pkg
// Types, widths and the reciprocal table shared by the moving average blocks.
// ----------------------------------------------------------------------------
package eama_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int MAX_HALF_W   = 7;
	localparam int HW_W         = 3;
	localparam int DEPTH        = 2 * MAX_HALF_W + 1;
	localparam int IDX_W        = $clog2(DEPTH + 1);
	localparam int SUM_W        = SAMPLE_W + IDX_W;
	localparam int MAG_W        = SUM_W - 1;
	localparam int RECIP_SHIFT  = MAG_W;
	localparam int RECIP_W      = RECIP_SHIFT + 1;
	localparam int QUO_W        = MAG_W + RECIP_W - RECIP_SHIFT;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [HW_W-1:0]  HW_RESET  = HW_W'(1);
	localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(15);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smoothed;
		logic                       last_output;
	} result_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [IDX_W-1:0] cnt;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// floor(2^RECIP_SHIFT / d), quotient estimate is exact or one low
	function automatic logic [RECIP_W-1:0] recip(input logic [IDX_W-1:0] d);
		logic [RECIP_W-1:0] r;
		case (d)
			IDX_W'(1):  r = RECIP_W'(524288);
			IDX_W'(2):  r = RECIP_W'(262144);
			IDX_W'(3):  r = RECIP_W'(174762);
			IDX_W'(4):  r = RECIP_W'(131072);
			IDX_W'(5):  r = RECIP_W'(104857);
			IDX_W'(6):  r = RECIP_W'(87381);
			IDX_W'(7):  r = RECIP_W'(74898);
			IDX_W'(8):  r = RECIP_W'(65536);
			IDX_W'(9):  r = RECIP_W'(58254);
			IDX_W'(10): r = RECIP_W'(52428);
			IDX_W'(11): r = RECIP_W'(47662);
			IDX_W'(12): r = RECIP_W'(43690);
			IDX_W'(13): r = RECIP_W'(40329);
			IDX_W'(14): r = RECIP_W'(37449);
			IDX_W'(15): r = RECIP_W'(34952);
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/eama_front.sv
// ----------------------------------------------------------------------------
// eama_front
// Takes samples, keeps prefix sums of the newest samples and issues one
// command per smoothed value due: window sum magnitude, sign, count, last.
// ----------------------------------------------------------------------------
module eama_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  eama_pkg::item_t          item,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [eama_pkg::HW_W-1:0] cfg_data,
	input  eama_pkg::q_stat_t        q_stat,
	output logic                     push,
	output eama_pkg::cmd_t           cmd
);
	import eama_pkg::*;

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	state_t                   state_q;
	logic [HW_W-1:0]          half_width_q;
	logic [HW_W-1:0]          w_q;
	logic [HW_W-1:0]          lead_q;
	logic [IDX_W-1:0]         seen_q;
	logic                     last_q;
	logic signed [SUM_W-1:0]  psum_q [DEPTH];

	logic                     accept;
	logic                     live;
	logic                     step;
	logic                     final_lead;
	logic [IDX_W-1:0]         reach;
	logic [IDX_W-1:0]         top;
	logic signed [SUM_W-1:0]  wsum;
	logic [SUM_W-1:0]         wabs;
	logic signed [SUM_W-1:0]  x_ext;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign x_ext      = SUM_W'(item.sample);

	// window top, bounded by the samples of this block
	assign reach = IDX_W'(lead_q) + IDX_W'(w_q);
	assign top   = (reach > seen_q - IDX_W'(1)) ? seen_q - IDX_W'(1) : reach;
	assign wsum  = psum_q[top];
	assign wabs  = wsum[SUM_W-1] ? SUM_W'(-wsum) : SUM_W'(wsum);

	assign live       = (state_q == ST_EMIT) && (IDX_W'(lead_q) < seen_q);
	assign push       = live && !q_stat.full;
	assign step       = (state_q == ST_EMIT) && (!live || !q_stat.full);
	assign final_lead = last_q ? (lead_q == '0) : (lead_q == w_q);

	assign cmd.neg  = wsum[SUM_W-1];
	assign cmd.mag  = wabs[MAG_W-1:0];
	assign cmd.cnt  = top + IDX_W'(1);
	assign cmd.last = last_q && (lead_q == '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (k == 0) begin
					psum_q[k] <= x_ext;
				end else begin
					psum_q[k] <= x_ext + psum_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			half_width_q <= HW_RESET;
			w_q          <= '0;
			lead_q       <= '0;
			seen_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				half_width_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (seen_q != COUNT_MAX) begin
							seen_q <= seen_q + IDX_W'(1);
						end
						last_q  <= item.last_sample;
						w_q     <= half_width_q;
						lead_q  <= half_width_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (step) begin
						if (final_lead) begin
							state_q <= ST_IDLE;
							if (last_q) begin
								seen_q <= '0;
							end
						end else begin
							lead_q <= lead_q - HW_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/eama_queue.sv
// ----------------------------------------------------------------------------
// eama_queue
// Short command queue between the front and the divide pipeline.
// ----------------------------------------------------------------------------
module eama_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  eama_pkg::cmd_t    wr_cmd,
	input  logic              pop,
	output eama_pkg::cmd_t    head,
	output eama_pkg::q_stat_t q_stat
);
	import eama_pkg::*;

	cmd_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head         = mem[rd_ptr_q];
	assign q_stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/eama_back.sv
// ----------------------------------------------------------------------------
// eama_back
// Divides each window sum by its count: reciprocal multiply, remainder
// check and one-step correction, sign restore, output register.
// ----------------------------------------------------------------------------
module eama_back (
	input  logic              clk,
	input  logic              arst_n,
	input  eama_pkg::cmd_t    head,
	input  eama_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output eama_pkg::result_t result
);
	import eama_pkg::*;

	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int QD_W   = QUO_W + IDX_W;

	logic              en;
	logic [PROD_W-1:0] prod;
	logic [QD_W-1:0]   qd;
	logic [QD_W-1:0]   rem;
	logic [QUO_W-1:0]  quo;
	logic [QUO_W-1:0]  sres;

	logic              v_s1;
	logic [QUO_W-1:0]  qa_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [IDX_W-1:0]  cnt_s1;
	logic              neg_s1;
	logic              last_s1;

	logic              v_s2;
	logic [QUO_W-1:0]  qa_s2;
	logic              corr_s2;
	logic              neg_s2;
	logic              last_s2;

	logic              out_v_q;
	result_t           result_q;

	assign en  = !out_v_q || !result_stall;
	assign pop = en && !q_stat.empty;

	assign prod = {{RECIP_W{1'b0}}, head.mag} * {{MAG_W{1'b0}}, recip(head.cnt)};
	assign qd   = {{IDX_W{1'b0}}, qa_s1} * {{QUO_W{1'b0}}, cnt_s1};
	assign rem  = {{(QD_W-MAG_W){1'b0}}, mag_s1} - qd;
	assign quo  = qa_s2 + QUO_W'(corr_s2);
	assign sres = neg_s2 ? -quo : quo;

	assign result_valid = out_v_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s1    <= prod[PROD_W-1:RECIP_SHIFT];
			mag_s1   <= head.mag;
			cnt_s1   <= head.cnt;
			neg_s1   <= head.neg;
			last_s1  <= head.last;
			qa_s2    <= qa_s1;
			corr_s2  <= (rem >= {{QUO_W{1'b0}}, cnt_s1});
			neg_s2   <= neg_s1;
			last_s2  <= last_s1;
			result_q.smoothed    <= sres[SAMPLE_W-1:0];
			result_q.last_output <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

endmodule

>>> rtl/edge_aware_moving_average.sv
// ----------------------------------------------------------------------------
// edge_aware_moving_average
// Centered moving average over a block of samples, window truncated at
// both block edges, mean truncated toward zero.
// ----------------------------------------------------------------------------
//  port group     dir  handshake              payload
//  item           in   item_valid/item_stall  sample, last_sample
//  result         out  result_valid/stall     smoothed, last_output
//  cfg            in   cfg_valid/cfg_ready    half width, 3 bits
//
//  the front takes a sample in its idle state and issues its command in its
//  emit state; the final sample of a block walks half width + 1 positions
//  there, one a cycle while the queue is not full. a full queue holds the front.
//  the divide pipeline takes one command a cycle while result_stall does not
//  hold it; a popped command passes the s1 and s2 registers, then the output register.
//  reset clears counters and queue and sets half width to 1; no clearing pass.
// ----------------------------------------------------------------------------
module edge_aware_moving_average (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  eama_pkg::item_t           item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output eama_pkg::result_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [eama_pkg::HW_W-1:0] cfg_data
);
	import eama_pkg::*;

	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	eama_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (push_cmd)
	);

	eama_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	eama_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> sim/tb_edge_aware_moving_average.sv
// ----------------------------------------------------------------------------
// tb_edge_aware_moving_average
// Self-checking bench for the edge-aware moving average. Sample blocks go in
// through a queue-fed driver and every accepted sample is run through a local
// model of the truncated-window mean. A monitor compares each result transfer
// with the oldest expected value. The run covers directed edge cases, three
// random phases with different back-pressure, and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_edge_aware_moving_average;

	import eama_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 300000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [HW_W-1:0]     cfg_data = '0;

	item_t               pending_items[$];
	result_t             expected_results[$];
	result_t             exp_r;

	logic signed [SAMPLE_W-1:0] hist [DEPTH];
	int                  blk_seen = 0;
	logic [HW_W-1:0]     half_width_now = HW_RESET;

	int                  send_idle_pct = 37;
	int                  recv_idle_pct = 79;
	bit                  hold_go = 1'b0;
	bit                  hold_taken = 1'b0;
	int                  hold_left = 0;
	int                  cycle_count = 0;
	int                  error_count = 0;

	edge_aware_moving_average u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_edge_aware_moving_average: errors");
			$finish;
		end
	end

	// expected smoothed values released by one accepted sample
	function automatic void predict_smoothed(input item_t it);
		int      k;
		int      lead;
		int      low;
		int      top;
		int      sum;
		int      w;
		int      q;
		result_t r;
		for (k = DEPTH - 1; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = it.sample;
		if (blk_seen < 15)
			blk_seen++;
		w = (half_width_now > MAX_HALF_W) ? MAX_HALF_W : int'(half_width_now);
		low = it.last_sample ? 0 : w;
		for (lead = w; lead >= low; lead--) begin
			if (lead >= blk_seen)
				continue;
			top = lead + w;
			if (top > blk_seen - 1)
				top = blk_seen - 1;
			sum = 0;
			for (k = 0; k <= top; k++)
				sum += int'(hist[k]);
			q = sum / (top + 1);
			r.smoothed = q[SAMPLE_W-1:0];
			r.last_output = it.last_sample && (lead == 0);
			expected_results.push_back(r);
		end
		if (it.last_sample)
			blk_seen = 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_smoothed(item);
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure, with one long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_go && !hold_taken) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: smoothed %0d last_output %0b",
					result.smoothed, result.last_output);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.smoothed !== exp_r.smoothed) begin
					$error("smoothed: expected %0d, got %0d", exp_r.smoothed, result.smoothed);
					error_count++;
				end
				if (result.last_output !== exp_r.last_output) begin
					$error("last_output: expected %0b, got %0b",
						exp_r.last_output, result.last_output);
					error_count++;
				end
			end
		end
	end

	task automatic queue_item(input int s, input bit l);
		item_t it;
		it.sample = s[SAMPLE_W-1:0];
		it.last_sample = l;
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_half_width(input logic [HW_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		half_width_now = v;
		@(negedge clk);
	endtask

	function automatic int rand_sample();
		logic [SAMPLE_W-1:0] raw;
		raw = SAMPLE_W'($urandom);
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 32767 : -32768;
			1: return int'($urandom_range(20)) - 10;
			default: return int'($signed(raw));
		endcase
	endfunction

	task automatic random_phase(input int n_items);
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 12);
			for (k = 0; k < len; k++)
				queue_item(rand_sample(), k == len - 1);
			sent += len;
		end
	endtask

	initial begin
		int k;
		for (k = 0; k < DEPTH; k++)
			hist[k] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset half width, single-sample block and extremes
		queue_item(32767, 1'b1);
		queue_item(-32768, 1'b0);
		queue_item(-32768, 1'b0);
		queue_item(-32768, 1'b1);
		queue_item(32767, 1'b0);
		queue_item(-1, 1'b0);
		queue_item(1, 1'b1);
		wait_idle();

		// pass-through
		write_half_width(HW_W'(0));
		queue_item(5, 1'b0);
		queue_item(-5, 1'b0);
		queue_item(-32768, 1'b1);
		wait_idle();

		// block shorter than the window, negative mean rounds toward zero
		write_half_width(HW_W'(MAX_HALF_W));
		queue_item(-7, 1'b0);
		queue_item(2, 1'b0);
		queue_item(0, 1'b0);
		queue_item(0, 1'b1);
		for (k = 0; k < 8; k++)
			queue_item(k * 1000 - 3500, 1'b0);
		wait_idle();

		// half width changed inside a block
		write_half_width(HW_W'(2));
		queue_item(-32768, 1'b0);
		queue_item(32767, 1'b0);
		queue_item(-3, 1'b1);
		wait_idle();

		write_half_width(HW_W'($urandom_range(MAX_HALF_W)));
		random_phase(100);
		wait_idle();

		send_idle_pct = 79;
		recv_idle_pct = 37;
		write_half_width(HW_W'($urandom_range(MAX_HALF_W)));
		random_phase(100);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_half_width(HW_W'($urandom_range(1, MAX_HALF_W)));
		hold_go = 1'b1;
		random_phase(90);
		wait_idle();

		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("tb_edge_aware_moving_average: clean");
		end else begin
			$display("tb_edge_aware_moving_average: errors");
		end
		$finish;
	end

endmodule
